[design/i2ctcf_pkg.sv]
// Shared types and constants for the I2C target command queue.
package i2ctcf_pkg;

  // Configuration port geometry
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  // Configuration register indexes (byte address is 4 * index)
  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_VERSION_BYTES = 3'd0;
  localparam reg_idx_t REG_VERSION_ADDR  = 3'd1;
  localparam reg_idx_t REG_READY_ADDR    = 3'd2;
  localparam reg_idx_t REG_RESET_ADDR    = 3'd3;
  localparam reg_idx_t REG_LED_FIRST     = 3'd4;
  localparam reg_idx_t REG_LED_MASK      = 3'd5;

  // Register reset values
  localparam logic [23:0] RST_VERSION_BYTES = 24'h010203;
  localparam logic [7:0]  RST_VERSION_ADDR  = 8'd1;
  localparam logic [7:0]  RST_READY_ADDR    = 8'd2;
  localparam logic [7:0]  RST_RESET_ADDR    = 8'd3;
  localparam logic [7:0]  RST_LED_FIRST     = 8'd4;
  localparam logic [7:0]  RST_LED_MASK      = 8'd9;

  // Fixed protocol constants
  localparam logic [7:0] READ_FILL       = 8'hFF;
  localparam int         VERSION_BYTES_N = 3;
  localparam int         LED_SINGLE_N    = 5;
  localparam logic [2:0] LED_SEL_MASK    = 3'd5;

  // Bus event codes
  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_POP   = 2'd3
  } cmd_e;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_READ   = 3'd0,
    KIND_LED    = 3'd1,
    KIND_HEADER = 3'd2,
    KIND_DATA   = 3'd3,
    KIND_EMPTY  = 3'd4
  } kind_e;

  // Message collection phase
  typedef enum logic [3:0] {
    PH_IDLE      = 4'b0001,
    PH_RECEIVE   = 4'b0010,
    PH_READ_ADDR = 4'b0100,
    PH_PENDING   = 4'b1000
  } phase_e;

  // Configuration register set
  typedef struct packed {
    logic [23:0] version_bytes;
    logic [7:0]  version_reg_addr;
    logic [7:0]  ready_reg_addr;
    logic [7:0]  reset_reg_addr;
    logic [7:0]  led_first_addr;
    logic [7:0]  led_mask_addr;
  } cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;    // take the input word this cycle
    logic exec;      // apply the latched event
    logic pop_byte;  // emit the next popped data byte
  } ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic emits;     // latched event produces a result word
    logic pop_data;  // latched pop streams data bytes after the header
    logic pop_last;  // current popped byte is the final one
    logic out_valid; // output register holds a word
  } status_t;

endpackage

[design/i2ctcf_cfg_regs.sv]
// APB-style configuration register block for the I2C target command queue.
module i2ctcf_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [i2ctcf_pkg::PADDR_W-1:0] paddr,
  input  logic [i2ctcf_pkg::PDATA_W-1:0] pwdata,
  output logic [i2ctcf_pkg::PDATA_W-1:0] prdata,
  output logic                          pready,
  output i2ctcf_pkg::cfg_t              cfg_o
);
  import i2ctcf_pkg::*;

  cfg_t     cfg_q;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = paddr[PADDR_W-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.version_bytes    <= RST_VERSION_BYTES;
      cfg_q.version_reg_addr <= RST_VERSION_ADDR;
      cfg_q.ready_reg_addr   <= RST_READY_ADDR;
      cfg_q.reset_reg_addr   <= RST_RESET_ADDR;
      cfg_q.led_first_addr   <= RST_LED_FIRST;
      cfg_q.led_mask_addr    <= RST_LED_MASK;
    end else if (wr_en) begin
      case (idx)
        REG_VERSION_BYTES: cfg_q.version_bytes    <= pwdata[23:0];
        REG_VERSION_ADDR:  cfg_q.version_reg_addr <= pwdata[7:0];
        REG_READY_ADDR:    cfg_q.ready_reg_addr   <= pwdata[7:0];
        REG_RESET_ADDR:    cfg_q.reset_reg_addr   <= pwdata[7:0];
        REG_LED_FIRST:     cfg_q.led_first_addr   <= pwdata[7:0];
        REG_LED_MASK:      cfg_q.led_mask_addr    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    prdata = '0;
    case (idx)
      REG_VERSION_BYTES: prdata = {8'd0, cfg_q.version_bytes};
      REG_VERSION_ADDR:  prdata = {24'd0, cfg_q.version_reg_addr};
      REG_READY_ADDR:    prdata = {24'd0, cfg_q.ready_reg_addr};
      REG_RESET_ADDR:    prdata = {24'd0, cfg_q.reset_reg_addr};
      REG_LED_FIRST:     prdata = {24'd0, cfg_q.led_first_addr};
      REG_LED_MASK:      prdata = {24'd0, cfg_q.led_mask_addr};
      default:           prdata = '0;
    endcase
  end

endmodule

[design/i2ctcf_ctrl.sv]
// Controller state machine for the I2C target command queue.
module i2ctcf_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  out_stall_i,
  input  i2ctcf_pkg::status_t   status_i,
  output i2ctcf_pkg::ctl_t      ctl_o
);
  import i2ctcf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_POP  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_free;

  // Output register can take a word this cycle
  assign out_free   = ~status_i.out_valid | ~out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  // Next state and commands
  always_comb begin
    state_d        = state_q;
    ctl_o.accept   = 1'b0;
    ctl_o.exec     = 1'b0;
    ctl_o.pop_byte = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.accept = 1'b1;
          state_d      = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!status_i.emits || out_free) begin
          ctl_o.exec = 1'b1;
          state_d    = status_i.pop_data ? S_POP : S_IDLE;
        end
      end
      S_POP: begin
        if (out_free) begin
          ctl_o.pop_byte = 1'b1;
          if (status_i.pop_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[design/i2ctcf_datapath.sv]
// Datapath of the I2C target command queue: message state, ring storage, output register.
module i2ctcf_datapath #(
  parameter int QUEUE_DEPTH    = 64,
  parameter int MSG_DATA_BYTES = 30
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  i2ctcf_pkg::cfg_t                    cfg_i,
  input  i2ctcf_pkg::ctl_t                    ctl_i,
  output i2ctcf_pkg::status_t                 status_o,
  input  logic [1:0]                          cmd_i,
  input  logic [7:0]                          byte_in_i,
  input  logic                                out_stall_i,
  output logic                                out_valid_o,
  output logic [2:0]                          kind_o,
  output logic [7:0]                          byte_out_o,
  output logic [2:0]                          led_select_o,
  output logic [7:0]                          message_reg_o,
  output logic [$clog2(MSG_DATA_BYTES+1)-1:0] message_len_o,
  output logic                                last_o,
  output logic                                not_empty_o
);
  import i2ctcf_pkg::*;

  localparam int PTR_W      = $clog2(QUEUE_DEPTH);
  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W      = $clog2(MSG_DATA_BYTES + 2);
  localparam int LEN_W      = $clog2(MSG_DATA_BYTES + 1);
  localparam int DIDX_W     = $clog2(MSG_DATA_BYTES);
  localparam int DATA_DEPTH = QUEUE_DEPTH * MSG_DATA_BYTES;
  localparam int DADDR_W    = $clog2(DATA_DEPTH);

  // Latched event
  cmd_e       cmd_q;
  logic [7:0] byte_q;

  // Message and ring state
  phase_e           phase_q;
  logic [PTR_W-1:0] rp_q, wp_q;
  logic [CNT_W-1:0] cnt_q;
  logic [IDX_W-1:0] bi_q;
  logic [QUEUE_DEPTH-1:0] reg_valid_q;

  // Storage
  logic [7:0]       reg_mem  [QUEUE_DEPTH];
  logic [IDX_W-1:0] len_mem  [QUEUE_DEPTH];
  logic [7:0]       data_mem [DATA_DEPTH];

  // Registered read data
  logic [7:0]       reg_rdata_q;
  logic             reg_rvalid_q;
  logic [IDX_W-1:0] len_rdata_q;
  logic [7:0]       data_rdata_q;

  // Pop streaming state
  logic [PTR_W-1:0] pop_slot_q;
  logic [LEN_W-1:0] pop_idx_q, pop_len_q;

  // Output register
  logic             out_valid_q;
  kind_e            kind_q;
  logic [7:0]       byte_out_q, msg_reg_q;
  logic [2:0]       led_sel_q;
  logic [LEN_W-1:0] msg_len_q;
  logic             last_q, ne_q;

  logic             full, q_nonempty;
  logic [7:0]       cur_reg, led_off, ver_byte;
  logic             is_ver, is_single, is_mask, is_led, is_raddr, ph_idle;
  logic [2:0]       led_sel;
  logic [LEN_W-1:0] len_clamped;
  logic [IDX_W:0]   bi_inc;
  logic [IDX_W-1:0] bi_wr_next;
  logic [PTR_W-1:0] wp_next, rp_next;
  logic             do_wr, wr_reg, wr_data, finish, enq, do_pop, do_ver;
  logic             pop_last, emits, out_load;
  logic [PTR_W-1:0] rd_slot;
  logic [LEN_W-1:0] rd_idx;
  logic             data_rd_en;
  logic [DADDR_W-1:0] data_raddr, data_waddr;
  cmd_e             cmd_in;

  // Ring status
  assign q_nonempty = (cnt_q != '0);
  assign full       = (rp_q == wp_q) && q_nonempty;
  assign ph_idle    = (phase_q == PH_IDLE);
  assign wp_next    = (wp_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp_q + PTR_W'(1);
  assign rp_next    = (rp_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_q + PTR_W'(1);

  // Register code of the addressed slot; never-written slots read zero
  assign cur_reg   = reg_rvalid_q ? reg_rdata_q : 8'd0;
  assign is_ver    = (cur_reg == cfg_i.version_reg_addr) &&
                     (bi_q < IDX_W'(VERSION_BYTES_N));
  assign led_off   = cur_reg - cfg_i.led_first_addr;
  assign is_single = (cur_reg >= cfg_i.led_first_addr) && (led_off < 8'(LED_SINGLE_N));
  assign is_mask   = (cur_reg == cfg_i.led_mask_addr);
  assign is_led    = is_single | is_mask;
  assign led_sel   = is_single ? led_off[2:0] : LED_SEL_MASK;
  assign is_raddr  = (byte_q == cfg_i.version_reg_addr) ||
                     (byte_q == cfg_i.ready_reg_addr) ||
                     (byte_q == cfg_i.reset_reg_addr);

  // Version byte, first byte in the top bits
  always_comb begin
    case (bi_q[1:0])
      2'd0:    ver_byte = cfg_i.version_bytes[23:16];
      2'd1:    ver_byte = cfg_i.version_bytes[15:8];
      default: ver_byte = cfg_i.version_bytes[7:0];
    endcase
  end

  // Stored length, capped at the slot size
  assign len_clamped = (len_rdata_q > IDX_W'(MSG_DATA_BYTES)) ?
                       LEN_W'(MSG_DATA_BYTES) : LEN_W'(len_rdata_q);

  // Data index advance with wrap back to one
  assign bi_inc     = {1'b0, bi_q} + (IDX_W+1)'(1);
  assign bi_wr_next = (bi_inc >= (IDX_W+1)'(MSG_DATA_BYTES)) ?
                      IDX_W'(1) : bi_inc[IDX_W-1:0];

  // Event decode
  assign do_wr   = ctl_i.exec && (cmd_q == CMD_WRITE) && !full;
  assign wr_reg  = do_wr && ph_idle;
  assign wr_data = do_wr && !ph_idle && (bi_q < IDX_W'(MSG_DATA_BYTES));
  assign finish  = ctl_i.exec && (cmd_q == CMD_STOP) && (phase_q == PH_RECEIVE);
  assign enq     = finish && !is_led;
  assign do_pop  = ctl_i.exec && (cmd_q == CMD_POP) && q_nonempty;
  assign do_ver  = ctl_i.exec && (cmd_q == CMD_READ) && is_ver;
  assign pop_last = ((pop_idx_q + LEN_W'(1)) == pop_len_q);

  always_comb begin
    case (cmd_q)
      CMD_WRITE: emits = 1'b0;
      CMD_READ:  emits = 1'b1;
      CMD_STOP:  emits = (phase_q == PH_RECEIVE) && is_led && (bi_q != '0);
      CMD_POP:   emits = 1'b1;
      default:   emits = 1'b0;
    endcase
  end

  assign status_o.emits     = emits;
  assign status_o.pop_data  = (cmd_q == CMD_POP) && q_nonempty && (len_clamped != '0);
  assign status_o.pop_last  = pop_last;
  assign status_o.out_valid = out_valid_q;

  // Latch the accepted word
  assign cmd_in = cmd_e'(cmd_i);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q <= CMD_WRITE;
    end else if (ctl_i.accept) begin
      cmd_q <= cmd_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      byte_q <= byte_in_i;
    end
  end

  // Message phase, pointers, count, data index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      rp_q        <= '0;
      wp_q        <= '0;
      cnt_q       <= '0;
      bi_q        <= '0;
      reg_valid_q <= '0;
    end else begin
      if (wr_reg) begin
        phase_q          <= is_raddr ? PH_READ_ADDR : PH_RECEIVE;
        reg_valid_q[wp_q] <= 1'b1;
      end
      if (do_wr && !ph_idle) begin
        bi_q <= bi_wr_next;
      end
      if (do_ver) begin
        bi_q <= bi_q + IDX_W'(1);
      end
      if (ctl_i.exec && (cmd_q == CMD_STOP)) begin
        if (phase_q == PH_READ_ADDR) begin
          phase_q <= PH_PENDING;
        end else begin
          phase_q <= PH_IDLE;
          bi_q    <= '0;
        end
      end
      if (enq) begin
        wp_q <= wp_next;
        if (cnt_q != CNT_W'(QUEUE_DEPTH)) begin
          cnt_q <= cnt_q + CNT_W'(1);
        end
      end
      if (do_pop) begin
        rp_q  <= rp_next;
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  // Read addressing: on accept, head slot for pops and write slot otherwise; pop slot while streaming
  always_comb begin
    if (ctl_i.accept) begin
      rd_slot = (cmd_in == CMD_POP) ? rp_q : wp_q;
      rd_idx  = '0;
    end else begin
      rd_slot = pop_slot_q;
      rd_idx  = pop_idx_q + LEN_W'(1);
    end
  end

  assign data_rd_en = ctl_i.accept || (ctl_i.pop_byte && !pop_last);
  assign data_raddr = DADDR_W'(rd_slot) * DADDR_W'(MSG_DATA_BYTES) +
                      DADDR_W'(rd_idx[DIDX_W-1:0]);
  assign data_waddr = DADDR_W'(wp_q) * DADDR_W'(MSG_DATA_BYTES) +
                      DADDR_W'(bi_q[DIDX_W-1:0]);

  // Slot tables: register code and length
  always_ff @(posedge clk_i) begin
    if (wr_reg) begin
      reg_mem[wp_q] <= byte_q;
    end
    if (finish) begin
      len_mem[wp_q] <= bi_q;
    end
    if (ctl_i.accept) begin
      reg_rdata_q <= reg_mem[rd_slot];
      len_rdata_q <= len_mem[rd_slot];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_rvalid_q <= 1'b0;
    end else if (ctl_i.accept) begin
      reg_rvalid_q <= reg_valid_q[rd_slot];
    end
  end

  // Message data bytes
  always_ff @(posedge clk_i) begin
    if (wr_data) begin
      data_mem[data_waddr] <= byte_q;
    end
    if (data_rd_en) begin
      data_rdata_q <= data_mem[data_raddr];
    end
  end

  // Pop streaming counters
  always_ff @(posedge clk_i) begin
    if (do_pop) begin
      pop_slot_q <= rp_q;
      pop_idx_q  <= '0;
      pop_len_q  <= len_clamped;
    end else if (ctl_i.pop_byte) begin
      pop_idx_q <= pop_idx_q + LEN_W'(1);
    end
  end

  // Output register
  assign out_load = (ctl_i.exec && emits) || ctl_i.pop_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      byte_out_q <= 8'd0;
      led_sel_q  <= 3'd0;
      msg_reg_q  <= 8'd0;
      msg_len_q  <= '0;
      last_q     <= 1'b1;
      ne_q       <= q_nonempty;
      if (ctl_i.pop_byte) begin
        kind_q     <= KIND_DATA;
        byte_out_q <= data_rdata_q;
        last_q     <= pop_last;
      end else begin
        case (cmd_q)
          CMD_READ: begin
            kind_q     <= KIND_READ;
            byte_out_q <= is_ver ? ver_byte : READ_FILL;
          end
          CMD_STOP: begin
            kind_q     <= KIND_LED;
            byte_out_q <= data_rdata_q;
            led_sel_q  <= led_sel;
          end
          CMD_POP: begin
            if (!q_nonempty) begin
              kind_q <= KIND_EMPTY;
            end else begin
              kind_q    <= KIND_HEADER;
              msg_reg_q <= cur_reg;
              msg_len_q <= len_clamped;
              last_q    <= (len_clamped == '0);
              ne_q      <= (cnt_q != CNT_W'(1));
            end
          end
          default: kind_q <= KIND_READ;
        endcase
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign byte_out_o    = byte_out_q;
  assign led_select_o  = led_sel_q;
  assign message_reg_o = msg_reg_q;
  assign message_len_o = msg_len_q;
  assign last_o        = last_q;
  assign not_empty_o   = ne_q;

endmodule

[design/i2c_target_command_fifo.sv]
// Top level of the I2C target command queue.
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one bus event word per handshake:
//   cmd_i selects byte written, read request, stop/restart or local pop; byte_in_i
//   carries the written byte. Output channel (out_valid_o / out_stall_i) delivers
//   result words: read data, LED commands, pop headers, data bytes, empty pops.
//   last_o marks the final result word of an event.
//   Each event has an accept step that reads the slot tables and message data
//   memory (registered read), then an execute step that loads the first result
//   word into the output register, waiting while the receiver stalls. A pop streams
//   its data bytes after the header at one byte per cycle unless the receiver
//   stalls; the next event is taken after the last byte. The single read port of
//   the data memory sets that streaming rate. Results sit in an output register;
//   a stalled receiver holds the word and the block waits before loading the next
//   one, but a new event is taken as soon as the last result of the previous event
//   is in the output register. Reset empties the queue, clears all register codes
//   of the ring (by per-slot valid bits, no clearing pass) and restores the
//   configuration defaults. Configuration is to be written by the user through the
//   APB-style port while the block is idle; the block does not enforce it.
module i2c_target_command_fifo #(
  parameter int QUEUE_DEPTH    = 64,
  parameter int MSG_DATA_BYTES = 30
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Event input
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [1:0]                           cmd_i,
  input  logic [7:0]                           byte_in_i,
  // Results
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [2:0]                           kind_o,
  output logic [7:0]                           byte_out_o,
  output logic [2:0]                           led_select_o,
  output logic [7:0]                           message_reg_o,
  output logic [$clog2(MSG_DATA_BYTES+1)-1:0]  message_len_o,
  output logic                                 last_o,
  output logic                                 not_empty_o,
  // Configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [i2ctcf_pkg::PADDR_W-1:0]       paddr,
  input  logic [i2ctcf_pkg::PDATA_W-1:0]       pwdata,
  output logic [i2ctcf_pkg::PDATA_W-1:0]       prdata,
  output logic                                 pready
);
  import i2ctcf_pkg::*;

  cfg_t    cfg;
  ctl_t    ctl;
  status_t status;

  i2ctcf_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  i2ctcf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .ctl_o       (ctl)
  );

  i2ctcf_datapath #(
    .QUEUE_DEPTH    (QUEUE_DEPTH),
    .MSG_DATA_BYTES (MSG_DATA_BYTES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .ctl_i         (ctl),
    .status_o      (status),
    .cmd_i         (cmd_i),
    .byte_in_i     (byte_in_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .kind_o        (kind_o),
    .byte_out_o    (byte_out_o),
    .led_select_o  (led_select_o),
    .message_reg_o (message_reg_o),
    .message_len_o (message_len_o),
    .last_o        (last_o),
    .not_empty_o   (not_empty_o)
  );

endmodule

[design/i2ctcf_checker.sv]
// Port-level checks for the I2C target command queue, bound to the top level.
module i2ctcf_checker #(
  parameter int LEN_W = 5
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [2:0]       kind_o,
  input logic [7:0]       byte_out_o,
  input logic [LEN_W-1:0] message_len_o,
  input logic             last_o,
  input logic             not_empty_o
);
  import i2ctcf_pkg::*;

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) &&
      $stable(byte_out_o) && $stable(last_o))
    else $error("result word changed while stalled");

  // One event at a time: an accepted word blocks the next cycle
  a_one_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken on back-to-back cycles");

  // Pop on empty queue ends the event and reports an empty queue
  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_EMPTY) |-> last_o && !not_empty_o)
    else $error("empty pop result malformed");

  // Header of an empty message is the final word
  a_hdr_len0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_HEADER) && (message_len_o == '0) |-> last_o)
    else $error("zero-length header not marked last");

endmodule

bind i2c_target_command_fifo i2ctcf_checker #(
  .LEN_W ($clog2(MSG_DATA_BYTES + 1))
) u_i2ctcf_checker (.*);

[tb/tb_top.sv]
// Self-checking testbench for the I2C target command queue with its own event predictor.
module tb_top;
  import i2ctcf_pkg::*;

  localparam int SLOTS        = 64;
  localparam int MSG_BYTES    = 30;
  localparam int SETTLE       = 8;
  localparam int END_SETTLE   = 20;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_LIMIT   = 5000;

  localparam cfg_t DEFAULT_CFG = '{
    version_bytes:    RST_VERSION_BYTES,
    version_reg_addr: RST_VERSION_ADDR,
    ready_reg_addr:   RST_READY_ADDR,
    reset_reg_addr:   RST_RESET_ADDR,
    led_first_addr:   RST_LED_FIRST,
    led_mask_addr:    RST_LED_MASK
  };

  // One expected result word
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  byte_v;
    logic [2:0]  sel;
    logic [7:0]  reg_code;
    logic [4:0]  len;
    logic        last;
    logic        not_empty;
  } word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  cmd_i = CMD_STOP;
  logic [7:0]  byte_in_i = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  kind_o;
  logic [7:0]  byte_out_o;
  logic [2:0]  led_select_o;
  logic [7:0]  message_reg_o;
  logic [4:0]  message_len_o;
  logic        last_o;
  logic        not_empty_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic        pready;

  i2c_target_command_fifo #(
    .QUEUE_DEPTH   (SLOTS),
    .MSG_DATA_BYTES(MSG_BYTES)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .byte_in_i    (byte_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .byte_out_o   (byte_out_o),
    .led_select_o (led_select_o),
    .message_reg_o(message_reg_o),
    .message_len_o(message_len_o),
    .last_o       (last_o),
    .not_empty_o  (not_empty_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state: mirrors the block's configuration, ring and collector
  cfg_t       model_cfg = DEFAULT_CFG;
  phase_e     ph = PH_IDLE;
  int         q_rd = 0;
  int         q_wr = 0;
  int         q_count = 0;
  int         collect_idx = 0;
  logic [7:0] slot_reg [SLOTS] = '{default: 8'h00};
  int         slot_len [SLOTS];
  logic [7:0] slot_data [SLOTS][MSG_BYTES];

  word_t expected_words[$];

  int  items_accepted = 0;
  int  words_checked = 0;
  int  fail_count = 0;
  int  settings_applied = 0;
  int  max_fill = 0;
  int  idle_cycles = 0;
  bit  steady = 1'b0;
  bit  hold_req = 1'b0;
  int  hold_left = 0;

  reg_idx_t cfg_regs [6] = '{REG_VERSION_BYTES, REG_VERSION_ADDR, REG_READY_ADDR,
                             REG_RESET_ADDR, REG_LED_FIRST, REG_LED_MASK};

  // Predict the words caused by one accepted bus event
  task automatic predict_bus_event(cmd_e c, logic [7:0] b);
    word_t res[$];
    word_t w;
    int t, h, n, code;
    bit full;
    t = q_wr;
    full = (q_rd == q_wr) && (q_count != 0);
    w = '0;
    case (c)
      CMD_WRITE: begin
        if (!full) begin
          if (ph == PH_IDLE) begin
            slot_reg[t] = b;
            if (b == model_cfg.version_reg_addr || b == model_cfg.ready_reg_addr ||
                b == model_cfg.reset_reg_addr)
              ph = PH_READ_ADDR;
            else
              ph = PH_RECEIVE;
          end else begin
            if (collect_idx < MSG_BYTES) slot_data[t][collect_idx] = b;
            collect_idx++;
            // index wraps to one once past the data area
            if (collect_idx >= MSG_BYTES) collect_idx = 1;
          end
        end
      end
      CMD_READ: begin
        w.kind = KIND_READ;
        if (slot_reg[t] == model_cfg.version_reg_addr && collect_idx < VERSION_BYTES_N) begin
          w.byte_v = model_cfg.version_bytes[8*(VERSION_BYTES_N-1-collect_idx) +: 8];
          collect_idx++;
        end else begin
          w.byte_v = READ_FILL;
        end
        res.push_back(w);
      end
      CMD_STOP: begin
        if (ph == PH_READ_ADDR) begin
          ph = PH_PENDING;
        end else begin
          if (ph == PH_RECEIVE) begin
            code = slot_reg[t];
            slot_len[t] = collect_idx;
            w.kind = KIND_LED;
            w.byte_v = slot_data[t][0];
            // single LEDs first, then the mask; empty LED writes vanish
            if (code >= model_cfg.led_first_addr &&
                code - model_cfg.led_first_addr < LED_SINGLE_N) begin
              w.sel = code - model_cfg.led_first_addr;
              if (collect_idx != 0) res.push_back(w);
            end else if (code == model_cfg.led_mask_addr) begin
              w.sel = LED_SEL_MASK;
              if (collect_idx != 0) res.push_back(w);
            end else begin
              if (q_count < SLOTS) q_count++;
              q_wr = (q_wr + 1) % SLOTS;
            end
          end
          ph = PH_IDLE;
          collect_idx = 0;
        end
      end
      default: begin
        if (q_count == 0) begin
          w.kind = KIND_EMPTY;
          res.push_back(w);
        end else begin
          h = q_rd;
          n = (slot_len[h] > MSG_BYTES) ? MSG_BYTES : slot_len[h];
          q_rd = (q_rd + 1) % SLOTS;
          q_count--;
          w.kind = KIND_HEADER;
          w.reg_code = slot_reg[h];
          w.len = n;
          res.push_back(w);
          for (int i = 0; i < n; i++) begin
            w = '0;
            w.kind = KIND_DATA;
            w.byte_v = slot_data[h][i];
            res.push_back(w);
          end
        end
      end
    endcase
    if (q_count > max_fill) max_fill = q_count;
    foreach (res[k]) begin
      res[k].not_empty = (q_count != 0);
      res[k].last = (k == res.size() - 1);
      expected_words.push_back(res[k]);
    end
  endtask

  function automatic void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  // Check each delivered word against the oldest expectation
  task automatic check_word();
    word_t w;
    if (expected_words.size() == 0) begin
      $error("result word with nothing expected: kind %0d byte %0d", kind_o, byte_out_o);
      fail_count++;
    end else begin
      w = expected_words.pop_front();
      compare_field("kind", w.kind, kind_o);
      compare_field("byte_out", w.byte_v, byte_out_o);
      compare_field("led_select", w.sel, led_select_o);
      compare_field("message_reg", w.reg_code, message_reg_o);
      compare_field("message_len", w.len, message_len_o);
      compare_field("last", w.last, last_o);
      compare_field("not_empty", w.not_empty, not_empty_o);
    end
    words_checked++;
  endtask

  // Monitor: check outgoing words first, then predict from the accepted event
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) check_word();
      if (in_valid_i && !in_stall_o) begin
        predict_bus_event(cmd_e'(cmd_i), byte_in_i);
        items_accepted++;
      end
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Receiver: random stalls, or a long counted hold-off on request
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall_i = 1'b1;
      hold_left--;
    end else begin
      out_stall_i = !steady && ($urandom_range(99) < 16);
    end
  end

  // Offer one word and wait until the monitor has taken it
  task automatic send_word(cmd_e c, logic [7:0] b);
    int n0;
    cmd_e c_use;
    if (!steady && $urandom_range(99) < 16) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat ($urandom_range(2)) @(negedge clk_i);
    end
    @(negedge clk_i);
    c_use = c;
    // an idle read of the version code would leave a stale collect index
    if (c == CMD_READ && ph == PH_IDLE && slot_reg[q_wr] == model_cfg.version_reg_addr)
      c_use = CMD_STOP;
    n0 = items_accepted;
    in_valid_i = 1'b1;
    cmd_i = c_use;
    byte_in_i = b;
    wait (items_accepted != n0);
  endtask

  task automatic wait_drained(int settle);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic apb_write(reg_idx_t r, logic [31:0] v);
    @(negedge clk_i);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = {r, 2'b00}; pwdata = v;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic apb_read(reg_idx_t r, output logic [31:0] v);
    @(negedge clk_i);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b0; paddr = {r, 2'b00};
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    v = prdata;
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0;
  endtask

  function automatic logic [31:0] cfg_field(cfg_t c, reg_idx_t r);
    case (r)
      REG_VERSION_BYTES: return {8'h00, c.version_bytes};
      REG_VERSION_ADDR:  return {24'h0, c.version_reg_addr};
      REG_READY_ADDR:    return {24'h0, c.ready_reg_addr};
      REG_RESET_ADDR:    return {24'h0, c.reset_reg_addr};
      REG_LED_FIRST:     return {24'h0, c.led_first_addr};
      REG_LED_MASK:      return {24'h0, c.led_mask_addr};
      default:           return '0;
    endcase
  endfunction

  task automatic verify_config();
    logic [31:0] v;
    foreach (cfg_regs[i]) begin
      apb_read(cfg_regs[i], v);
      compare_field($sformatf("config register %0d", cfg_regs[i]),
                    cfg_field(model_cfg, cfg_regs[i]), v);
    end
  endtask

  // Close any open transfer, let the block go idle, then reprogram
  task automatic program_config(cfg_t c);
    send_word(CMD_STOP, $urandom_range(255));
    send_word(CMD_STOP, $urandom_range(255));
    wait_drained(SETTLE);
    foreach (cfg_regs[i]) apb_write(cfg_regs[i], cfg_field(c, cfg_regs[i]));
    model_cfg = c;
    settings_applied++;
    verify_config();
  endtask

  // Write transfer: register code, data bytes, optional read in between, stop
  task automatic send_message(logic [7:0] code, int n_bytes, bit read_mid);
    send_word(CMD_WRITE, code);
    for (int i = 0; i < n_bytes; i++) begin
      if (read_mid && i == n_bytes / 2) send_word(CMD_READ, $urandom_range(255));
      send_word(CMD_WRITE, $urandom_range(255));
    end
    send_word(CMD_STOP, $urandom_range(255));
  endtask

  // Register read: address write (with optional stray bytes), restart, reads, stop
  task automatic send_read_session(logic [7:0] code, int n_bytes, int n_reads);
    send_word(CMD_WRITE, code);
    repeat (n_bytes) send_word(CMD_WRITE, $urandom_range(255));
    send_word(CMD_STOP, $urandom_range(255));
    repeat (n_reads) send_word(CMD_READ, $urandom_range(255));
    send_word(CMD_STOP, $urandom_range(255));
  endtask

  // A code that is neither a read register nor an LED register
  function automatic logic [7:0] plain_code();
    logic [7:0] c;
    do begin
      c = $urandom_range(255);
    end while (c == model_cfg.version_reg_addr || c == model_cfg.ready_reg_addr ||
               c == model_cfg.reset_reg_addr || c == model_cfg.led_mask_addr ||
               (c >= model_cfg.led_first_addr &&
                c - model_cfg.led_first_addr < LED_SINGLE_N));
    return c;
  endfunction

  // Mostly well-formed transfers with random content, some noise
  task automatic random_mix(int count);
    int stop_at, r, n;
    logic [7:0] code;
    stop_at = items_accepted + count;
    while (items_accepted < stop_at) begin
      r = $urandom_range(99);
      if (r < 50) begin
        r = $urandom_range(99);
        if (r < 15)
          code = model_cfg.led_first_addr + $urandom_range(LED_SINGLE_N - 1);
        else if (r < 22)
          code = model_cfg.led_mask_addr;
        else
          code = $urandom_range(255);
        // occasional long message runs past the data area and wraps
        n = ($urandom_range(9) == 0) ? $urandom_range(25, 40) : $urandom_range(6);
        send_message(code, n, $urandom_range(99) < 15);
      end else if (r < 65) begin
        case ($urandom_range(2))
          0:       code = model_cfg.version_reg_addr;
          1:       code = model_cfg.ready_reg_addr;
          default: code = model_cfg.reset_reg_addr;
        endcase
        send_read_session(code, $urandom_range(2), $urandom_range(5));
      end else if (r < 85) begin
        send_word(CMD_POP, $urandom_range(255));
      end else begin
        send_word(cmd_e'($urandom_range(3)), $urandom_range(255));
      end
    end
  endtask

  task automatic test_reset_defaults();
    verify_config();
  endtask

  // Short directed pass over every event and the special cases
  task automatic test_directed();
    send_word(CMD_POP, 8'h00);                       // empty ring
    send_read_session(RST_VERSION_ADDR, 0, 4);       // version bytes then fill
    send_message(RST_LED_FIRST, 1, 0);               // first single LED
    send_message(RST_LED_FIRST + 8'd4, 1, 0);        // last single LED
    send_message(RST_LED_MASK, 2, 0);                // LED mask
    send_message(RST_LED_FIRST + 8'd1, 0, 0);        // LED write with no data
    send_message(8'h00, 0, 0);                       // empty message queued
    send_message(8'hFF, 2, 1);                       // read inside a write
    send_read_session(RST_READY_ADDR, 0, 1);
    repeat (3) send_word(CMD_POP, 8'hFF);
  endtask

  // Fill the ring past capacity, probe it full, drain under receiver hold-off
  task automatic test_queue_full();
    while (q_count != 0) send_word(CMD_POP, $urandom_range(255));
    for (int i = 0; i < SLOTS + 2; i++)
      send_message(plain_code(), (i % 16 == 0) ? 1 : 0, 0);
    send_word(CMD_WRITE, $urandom_range(255));
    send_word(CMD_READ, $urandom_range(255));
    send_word(CMD_STOP, $urandom_range(255));
    hold_req = 1'b1;
    while (q_count != 0) send_word(CMD_POP, $urandom_range(255));
    send_word(CMD_POP, $urandom_range(255));
  endtask

  // Traffic under extreme, random and default register settings
  task automatic test_config_sweep();
    cfg_t c;
    c = '{version_bytes: 24'hFFFFFF, version_reg_addr: 8'hFF, ready_reg_addr: 8'h00,
          reset_reg_addr: 8'h80, led_first_addr: 8'd251, led_mask_addr: 8'h00};
    program_config(c);
    random_mix(4);
    c = '{version_bytes: 24'h000000, version_reg_addr: 8'h00, ready_reg_addr: 8'hFF,
          reset_reg_addr: 8'hFE, led_first_addr: 8'h00, led_mask_addr: 8'h05};
    program_config(c);
    random_mix(4);
    c.version_bytes    = $urandom_range(24'hFFFFFF);
    c.version_reg_addr = $urandom_range(255);
    c.ready_reg_addr   = $urandom_range(255);
    c.reset_reg_addr   = $urandom_range(255);
    c.led_first_addr   = $urandom_range(251);
    c.led_mask_addr    = $urandom_range(255);
    program_config(c);
    random_mix(4);
    // back to defaults with a stretch free of idling on both sides
    program_config(DEFAULT_CFG);
    steady = 1'b1;
    random_mix(12);
    steady = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_defaults();
    test_directed();
    test_queue_full();
    test_config_sweep();
    wait_drained(END_SETTLE);
    $display("Ran %0d bus events and checked %0d result words over %0d register settings;",
             items_accepted, words_checked, settings_applied + 1);
    $display("ring filled to %0d entries, drained under a %0d-cycle receiver hold-off.",
             max_fill, HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
